### hw/rtl/pclb_pkg.sv
`default_nettype none
// Package for the pot-controlled LED blinker: item structs, opcodes, FSM states,
// divider load struct and fixed constants. No dependencies.

package pclb_pkg;

   localparam int unsigned LEVEL_W = 12;
   localparam int unsigned MS_W    = 10;
   localparam int unsigned DVS_W   = 16;
   localparam int unsigned STEP_W  = 4;

   // Input item opcodes; code 3 does nothing.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_PRESS  = 2'd2;

   // Register index, taken from paddr bit 2.
   localparam logic CSR_DEBOUNCE_IDX = 1'b0;

   localparam logic [MS_W-1:0]    DEBOUNCE_RESET = 10'd200;
   localparam logic [MS_W-1:0]    PHASE_RESET    = 10'd500;
   localparam logic [MS_W-1:0]    GAP_MAX        = 10'd1023;
   localparam logic [DVS_W-1:0]   LEVEL_FULL     = 16'd4095;
   // floor(p * 205 / 1024) == floor(p / 5) for every period below 1024
   localparam logic [7:0]         FIFTH_RECIP    = 8'd205;

   // Period divide: 4095000 / D. The quotient never exceeds 1000, so the top
   // dividend bits preload the remainder and only ten steps remain.
   localparam int unsigned        SCALE          = 4095000;
   localparam logic [STEP_W-1:0]  PER_STEPS      = 4'd10;
   localparam logic [STEP_W-1:0]  AVG_STEPS      = 4'd12;
   localparam logic [DVS_W-1:0]   PER_REM_INIT   = DVS_W'(SCALE >> 10);
   localparam logic [LEVEL_W-1:0] PER_BITS_INIT  = LEVEL_W'((SCALE % 1024) << 2);

   typedef struct packed {
      logic [1:0]         op;
      logic [LEVEL_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic               led;
      logic [LEVEL_W-1:0] filtered_level;
      logic               mode;
   } rsp_type;

   // Everything the divider needs at start.
   typedef struct packed {
      logic [DVS_W-1:0]   rem;
      logic [LEVEL_W-1:0] bits;
      logic [STEP_W-1:0]  steps;
      logic [DVS_W-1:0]   divisor;
   } div_load_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RING,
      ST_AVG_GO,
      ST_AVG,
      ST_PER_GO,
      ST_PER,
      ST_ON,
      ST_OFF,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

### hw/rtl/pclb_ring.sv
`default_nettype none
// Sample ring for the moving average: one write and one registered read per push.
// Depends on pclb_pkg.

module pclb_ring #(
   parameter int TAPS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [pclb_pkg::LEVEL_W-1:0]  push_data,
   output logic [pclb_pkg::LEVEL_W-1:0]  old_data
);

   localparam int SLOT_W = $clog2(TAPS);

   logic [pclb_pkg::LEVEL_W-1:0] mem [TAPS];
   logic [pclb_pkg::LEVEL_W-1:0] rd_ff;
   logic                         rd_vld_ff;
   logic [TAPS-1:0]              valid_ff;
   logic [SLOT_W-1:0]            slot_ff;
   logic [SLOT_W-1:0]            slot_in;

   assign slot_in  = (slot_ff == SLOT_W'(TAPS - 1)) ? '0 : slot_ff + 1'b1;
   // an entry never written reads as zero
   assign old_data = rd_vld_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      if (push) begin
         rd_ff         <= mem[slot_ff];
         mem[slot_ff]  <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else if (push) begin
         slot_ff           <= slot_in;
         valid_ff[slot_ff] <= 1'b1;
         rd_vld_ff         <= valid_ff[slot_ff];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/pclb_div.sv
`default_nettype none
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// average and the period computation. Depends on pclb_pkg.

module pclb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  pclb_pkg::div_load_type        load,
   output logic [pclb_pkg::LEVEL_W-1:0]  quot,
   output logic                          done
);

   logic [pclb_pkg::DVS_W-1:0]   rem_ff;
   logic [pclb_pkg::DVS_W-1:0]   rem_in;
   logic [pclb_pkg::DVS_W-1:0]   dvs_ff;
   logic [pclb_pkg::LEVEL_W-1:0] bits_ff;
   logic [pclb_pkg::LEVEL_W-1:0] q_ff;
   logic [pclb_pkg::STEP_W-1:0]  cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;
   logic [pclb_pkg::DVS_W:0]     trial;
   logic [pclb_pkg::DVS_W:0]     diff;
   logic                         fits;

   // remainder stays below the divisor, so it fits DVS_W bits
   assign trial  = {rem_ff, bits_ff[pclb_pkg::LEVEL_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign rem_in = fits ? diff[pclb_pkg::DVS_W-1:0] : trial[pclb_pkg::DVS_W-1:0];

   assign quot = q_ff;
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= load.rem;
         bits_ff <= load.bits;
         dvs_ff  <= load.divisor;
         q_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         bits_ff <= {bits_ff[pclb_pkg::LEVEL_W-2:0], 1'b0};
         q_ff    <= {q_ff[pclb_pkg::LEVEL_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == pclb_pkg::STEP_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= load.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == pclb_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/pot_controlled_led_blinker.sv
`default_nettype none
// Top level of the pot-controlled LED blinker: control FSM, blink and debounce
// state, result register and config register. Depends on pclb_pkg, pclb_ring, pclb_div.
//
//   Channel  Ports                          Direction  Carries
//   req      req_valid/req_stall/req_data   in         one event item (tick, sample, press)
//   rsp      rsp_valid/rsp_stall/rsp_data   out        one result item per event
//   csr      csr_p* (APB style)             in/out     debounce_ms at byte address 0
//
// A tick that does not open a period, a press or an unused code goes from accept to
// ST_OUT. A sample passes ST_RING, ST_AVG_GO and ST_AVG, and a tick that opens a period
// ST_PER_GO, ST_PER, ST_ON and ST_OFF, before ST_OUT; both wait on the bit-serial
// divider (12 steps for the average, 10 for the period). One item is in work at a time;
// the next is taken once the result register has been loaded, even if that result is
// still stalled. Reset is synchronous; ring entries carry valid bits, no sweep.

module pot_controlled_led_blinker #(
   parameter int TAPS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pclb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pclb_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int SLOT_W = $clog2(TAPS);
   localparam int SUM_W  = pclb_pkg::LEVEL_W + SLOT_W;
   localparam int LVL    = pclb_pkg::LEVEL_W;
   localparam int MS     = pclb_pkg::MS_W;

   pclb_pkg::state_type state_ff, state_in;

   // model state
   logic [MS-1:0]    debounce_ff, debounce_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [LVL-1:0]   f_ff, f_in;
   logic             duty_ff, duty_in;
   logic [MS-1:0]    gap_ff, gap_in;
   logic             led_ff, led_in;
   logic [MS-1:0]    phase_ff, phase_in;
   logic [MS-1:0]    off_hold_ff, off_hold_in;

   // per-item working registers
   logic [LVL-1:0]   smp_ff, smp_in;
   logic             shown_ff, shown_in;
   logic [MS-1:0]    period_ff, period_in;
   logic [MS-1:0]    on_ff, on_in;

   logic              rsp_valid_ff, rsp_valid_in;
   pclb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   csr_wr;
   logic                   ring_push;
   logic [LVL-1:0]         ring_old;
   logic                   div_start;
   pclb_pkg::div_load_type div_load;
   logic [LVL-1:0]         div_quot;
   logic                   div_done;
   logic                   out_load;
   logic [MS-1:0]          phase_dec;
   logic                   need_period;
   logic [pclb_pkg::DVS_W-1:0] blink_d;
   logic [MS+7:0]          fifth_prod;

   // ---------------------------------------------------------------- config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == pclb_pkg::CSR_DEBOUNCE_IDX);
   assign csr_prdata = (csr_paddr[2] == pclb_pkg::CSR_DEBOUNCE_IDX) ?
                       {{(32-MS){1'b0}}, debounce_ff} : '0;

   // ---------------------------------------------------------------- submodules
   pclb_ring #(
      .TAPS (TAPS)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (ring_push),
      .push_data (req_data.sample),
      .old_data  (ring_old)
   );

   pclb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .load  (div_load),
      .quot  (div_quot),
      .done  (div_done)
   );

   // ---------------------------------------------------------------- tick decode
   // Count the phase down; on reaching zero either drop to the off phase or open
   // a new period (off phase over, or an off phase of zero length).
   assign phase_dec   = (phase_ff == '0) ? '0 : phase_ff - 1'b1;
   assign need_period = (phase_dec == '0) && (!led_ff || (off_hold_ff == '0));

   // D = 4095 + 9f, with 9f as f*8 + f
   assign blink_d = pclb_pkg::LEVEL_FULL + {1'b0, f_ff, 3'b000} + {4'b0000, f_ff};

   // one multiply for the 20 percent on time, registered into on_ff
   assign fifth_prod = period_ff * pclb_pkg::FIFTH_RECIP;

   // ---------------------------------------------------------------- FSM next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pclb_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  pclb_pkg::OP_TICK: begin
                     state_in = need_period ? pclb_pkg::ST_PER_GO : pclb_pkg::ST_OUT;
                  end
                  pclb_pkg::OP_SAMPLE: begin
                     state_in = pclb_pkg::ST_RING;
                  end
                  default: begin
                     state_in = pclb_pkg::ST_OUT;
                  end
               endcase
            end
         end
         pclb_pkg::ST_RING:   state_in = pclb_pkg::ST_AVG_GO;
         pclb_pkg::ST_AVG_GO: state_in = pclb_pkg::ST_AVG;
         pclb_pkg::ST_AVG: begin
            if (div_done) begin
               state_in = pclb_pkg::ST_OUT;
            end
         end
         pclb_pkg::ST_PER_GO: state_in = pclb_pkg::ST_PER;
         pclb_pkg::ST_PER: begin
            if (div_done) begin
               state_in = pclb_pkg::ST_ON;
            end
         end
         pclb_pkg::ST_ON:     state_in = pclb_pkg::ST_OFF;
         pclb_pkg::ST_OFF:    state_in = pclb_pkg::ST_OUT;
         pclb_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = pclb_pkg::ST_IDLE;
            end
         end
         default: state_in = pclb_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- FSM outputs
   always_comb begin
      // hold the input off while in reset and while an item is in work
      req_stall = reset || (state_ff != pclb_pkg::ST_IDLE);
      accept    = req_valid && !req_stall;
      ring_push = accept && (req_data.op == pclb_pkg::OP_SAMPLE);
      div_start = (state_ff == pclb_pkg::ST_AVG_GO) || (state_ff == pclb_pkg::ST_PER_GO);
      // result register is free, or its item leaves this cycle
      out_load  = (state_ff == pclb_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
      if (state_ff == pclb_pkg::ST_PER_GO) begin
         div_load.rem     = pclb_pkg::PER_REM_INIT;
         div_load.bits    = pclb_pkg::PER_BITS_INIT;
         div_load.steps   = pclb_pkg::PER_STEPS;
         div_load.divisor = blink_d;
      end else begin
         // sum / TAPS: the bits above the low LEVEL_W are always below TAPS
         div_load.rem     = pclb_pkg::DVS_W'(sum_ff >> LVL);
         div_load.bits    = sum_ff[LVL-1:0];
         div_load.steps   = pclb_pkg::AVG_STEPS;
         div_load.divisor = pclb_pkg::DVS_W'(TAPS);
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      debounce_in = debounce_ff;
      sum_in      = sum_ff;
      f_in        = f_ff;
      duty_in     = duty_ff;
      gap_in      = gap_ff;
      led_in      = led_ff;
      phase_in    = phase_ff;
      off_hold_in = off_hold_ff;
      smp_in      = smp_ff;
      shown_in    = shown_ff;
      period_in   = period_ff;
      on_in       = on_ff;

      if (csr_wr) begin
         debounce_in = csr_pwdata[MS-1:0];
      end

      if (accept) begin
         shown_in = led_ff;       // tick reports the level of the millisecond it closes
         smp_in   = req_data.sample;
         case (req_data.op)
            pclb_pkg::OP_TICK: begin
               if (gap_ff != pclb_pkg::GAP_MAX) begin
                  gap_in = gap_ff + 1'b1;
               end
               if (phase_dec != '0) begin
                  phase_in = phase_dec;
               end else if (led_ff) begin
                  led_in   = 1'b0;
                  phase_in = off_hold_ff;
               end
            end
            pclb_pkg::OP_PRESS: begin
               if (gap_ff > debounce_ff) begin
                  duty_in = ~duty_ff;
                  gap_in  = '0;
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         pclb_pkg::ST_RING: begin
            // drop the oldest sample, add the new one
            sum_in = sum_ff - SUM_W'(ring_old) + SUM_W'(smp_ff);
         end
         pclb_pkg::ST_AVG: begin
            if (div_done) begin
               f_in = div_quot;
            end
         end
         pclb_pkg::ST_PER: begin
            if (div_done) begin
               period_in = div_quot[MS-1:0];
            end
         end
         pclb_pkg::ST_ON: begin
            on_in = duty_ff ? fifth_prod[MS+7:8] >> 2 : {1'b0, period_ff[MS-1:1]};
         end
         pclb_pkg::ST_OFF: begin
            led_in      = 1'b1;
            phase_in    = on_ff;
            off_hold_in = period_ff - on_ff;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.led            = shown_ff;
         rsp_data_in.filtered_level = f_ff;
         rsp_data_in.mode           = duty_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pclb_pkg::ST_IDLE;
         debounce_ff  <= pclb_pkg::DEBOUNCE_RESET;
         sum_ff       <= '0;
         f_ff         <= '0;
         duty_ff      <= 1'b0;
         gap_ff       <= '0;
         led_ff       <= 1'b1;
         phase_ff     <= pclb_pkg::PHASE_RESET;
         off_hold_ff  <= pclb_pkg::PHASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         debounce_ff  <= debounce_in;
         sum_ff       <= sum_in;
         f_ff         <= f_in;
         duty_ff      <= duty_in;
         gap_ff       <= gap_in;
         led_ff       <= led_in;
         phase_ff     <= phase_in;
         off_hold_ff  <= off_hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      shown_ff    <= shown_in;
      period_ff   <= period_in;
      on_ff       <= on_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

### hw/rtl/pclb_checker.sv
`default_nettype none
// Port-level checks for the pot-controlled LED blinker, bound to the top level.
// Depends on pclb_pkg and pot_controlled_led_blinker.

module pclb_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pclb_pkg::rsp_type rsp_data,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [2:0]        csr_paddr,
   input logic [31:0]       csr_pwdata,
   input logic [31:0]       csr_prdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // one item in work: stall the input right after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // debounce register comes out of reset at its default
   a_csr_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (csr_paddr[2] != pclb_pkg::CSR_DEBOUNCE_IDX) ||
                       (csr_prdata == {22'b0, pclb_pkg::DEBOUNCE_RESET}))
      else $error("debounce register wrong after reset");

   // a write is read back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite &&
      (csr_paddr[2] == pclb_pkg::CSR_DEBOUNCE_IDX)
      |=> (csr_paddr[2] != pclb_pkg::CSR_DEBOUNCE_IDX) ||
          (csr_prdata == {22'b0, $past(csr_pwdata[9:0])}))
      else $error("debounce register write lost");

endmodule

bind pot_controlled_led_blinker pclb_port_checker u_pclb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
`default_nettype wire
